### hw/rtl/c2rsb_pkg.sv
// Shared types, widths and constants for the column-to-row span builder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package c2rsb_pkg;

   // Field widths fixed by the channel formats.
   localparam int X_IN_W     = 12;
   localparam int ROW_W      = 6;
   localparam int BOT_W      = 7;
   localparam int XF_W       = 11;
   localparam int VH_W       = 7;

   // Width of the internal signed row arithmetic.
   localparam int ROW_CALC_W = 9;

   // Defaults for the top-level parameters.
   localparam int MAX_ROWS_DEF    = 64;
   localparam int COLUMN_BITS_DEF = 11;

   // Visible row count after reset.
   localparam logic [VH_W-1:0] VIEW_HEIGHT_RESET = 7'd64;

   typedef logic signed [ROW_CALC_W-1:0] row_calc_type;

   // Stand-in for the top row of a column that covers nothing. Any value well
   // above the deepest row gives the same comparisons.
   localparam row_calc_type ROW_NONE      = 9'sd200;
   localparam row_calc_type ROW_ONE       = 9'sd1;
   localparam row_calc_type ROW_MINUS_ONE = -9'sd1;

   // One accepted column request.
   typedef struct packed {
      logic [X_IN_W-1:0]       column_x;
      logic [ROW_W-1:0]        column_top;
      logic signed [BOT_W-1:0] column_bottom;
      logic                    column_empty;
      logic                    plane_start;
   } req_payload_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOP_CLOSE,
      ST_BOT_CLOSE,
      ST_TOP_OPEN,
      ST_BOT_OPEN
   } state_type;

   // Row sweep that the datapath works on.
   typedef enum logic [1:0] {
      PH_TOP_CLOSE,
      PH_BOT_CLOSE,
      PH_TOP_OPEN,
      PH_BOT_OPEN
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      load;
      phase_type phase;
      logic      step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;
      logic emit_room;
   } status_type;

endpackage

### hw/rtl/c2rsb_req_if.sv
// Column request channel: valid, ready and the column fields.
// Depends on c2rsb_pkg for the field widths.
`timescale 1ns / 1ps

interface c2rsb_req_if import c2rsb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [X_IN_W-1:0]       column_x;
   logic [ROW_W-1:0]        column_top;
   logic signed [BOT_W-1:0] column_bottom;
   logic                    column_empty;
   logic                    plane_start;

   modport source (
      output valid, column_x, column_top, column_bottom, column_empty, plane_start,
      input  ready
   );

   modport sink (
      input  valid, column_x, column_top, column_bottom, column_empty, plane_start,
      output ready
   );
endinterface

### hw/rtl/c2rsb_rsp_if.sv
// Span response channel: valid, ready and the span fields.
// Depends on c2rsb_pkg for the field widths.
`timescale 1ns / 1ps

interface c2rsb_rsp_if import c2rsb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  span_row;
   logic [XF_W-1:0]   span_x_start;
   logic [XF_W-1:0]   span_x_end;
   logic              span_last;

   modport source (
      output valid, span_row, span_x_start, span_x_end, span_last,
      input  ready
   );

   modport sink (
      input  valid, span_row, span_x_start, span_x_end, span_last,
      output ready
   );
endinterface

### hw/rtl/c2rsb_csr_if.sv
// Configuration write channel carrying the view height register value.
// Depends on c2rsb_pkg for the register width.
`timescale 1ns / 1ps

interface c2rsb_csr_if import c2rsb_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [VH_W-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );

   modport sink (
      input  valid, data,
      output ready
   );
endinterface

### hw/rtl/column_to_row_span_builder_unit.sv
// Top level of the column-to-row span builder: sequencer plus datapath.
// Depends on c2rsb_pkg, the three channel interfaces, c2rsb_ctrl, c2rsb_datapath.
`timescale 1ns / 1ps

// Usage:
// Columns of one plane arrive left to right on req_if; plane_start marks the
// first column of a plane and a final empty column flushes the open rows.
// Each column may close spans, which leave on rsp_if as row, start x and end
// x, top rows going down and then bottom rows going up; span_last marks the
// final span of a column. A column that closes nothing gives no response.
// csr_if writes the visible row count and is always ready; it must be written
// only while no column is in progress, which the block does not enforce.
// The sequencer steps one row per cycle through the single-port span start
// memory, for each span closed and each row opened. A span passes through the
// span stage and then the response register on its way to rsp_if.
// req_if is ready again once the column's sweeps are done, even while its
// last span still waits in the response register. A stalled receiver holds
// the span stage and response register, and the close sweeps wait for room.
// Reset restores a row count of 64 and an empty previous column; the span
// start memory is not cleared and holds nothing until rows are opened.
module column_to_row_span_builder_unit import c2rsb_pkg::*; #(
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   c2rsb_req_if.sink   req_if,
   c2rsb_rsp_if.source rsp_if,
   c2rsb_csr_if.sink   csr_if
);

   cmd_type         cmd;
   status_type      status;
   req_payload_type req;
   logic            ctrl_ready;

   // Gather the request fields for the datapath.
   assign req.column_x      = req_if.column_x;
   assign req.column_top    = req_if.column_top;
   assign req.column_bottom = req_if.column_bottom;
   assign req.column_empty  = req_if.column_empty;
   assign req.plane_start   = req_if.plane_start;
   assign req_if.ready      = ctrl_ready;

   // Sequencer.
   c2rsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctrl_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   c2rsb_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cmd    (cmd),
      .status (status),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

endmodule

### hw/rtl/c2rsb_ctrl.sv
// Sequencer for the span builder: walks the four row sweeps of one column.
// Depends on c2rsb_pkg for the state, command and status types.
`timescale 1ns / 1ps

module c2rsb_ctrl import c2rsb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands. A close sweep steps only when the span stage
   // has room; every sweep leaves once the datapath reports no more rows.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.phase  = PH_TOP_CLOSE;
      cmd.step   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TOP_CLOSE;
            end
         end
         ST_TOP_CLOSE: begin
            cmd.phase = PH_TOP_CLOSE;
            if (status.more) begin
               cmd.step = status.emit_room;
            end else begin
               state_in = ST_BOT_CLOSE;
            end
         end
         ST_BOT_CLOSE: begin
            cmd.phase = PH_BOT_CLOSE;
            if (status.more) begin
               cmd.step = status.emit_room;
            end else begin
               state_in = ST_TOP_OPEN;
            end
         end
         ST_TOP_OPEN: begin
            cmd.phase = PH_TOP_OPEN;
            if (status.more) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_BOT_OPEN;
            end
         end
         ST_BOT_OPEN: begin
            cmd.phase = PH_BOT_OPEN;
            if (status.more) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/c2rsb_datapath.sv
// Datapath of the span builder: extents, row cursors, span start memory,
// span stage and response register. Depends on c2rsb_pkg, rsp and csr channels.
`timescale 1ns / 1ps

module c2rsb_datapath import c2rsb_pkg::*; #(
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req,
   input  cmd_type         cmd,
   output status_type      status,
   c2rsb_rsp_if.source     rsp_if,
   c2rsb_csr_if.sink       csr_if
);

   localparam int ADDR_W = $clog2(MAX_ROWS);
   localparam logic [VH_W-1:0] MAX_ROWS_VH = VH_W'(MAX_ROWS);
   localparam row_calc_type MAX_ROWS_CALC = row_calc_type'(MAX_ROWS);

   // Configuration and previous column extent.
   logic [VH_W-1:0]         view_height_ff;
   logic [ROW_W-1:0]        prev_top_ff;
   logic signed [BOT_W-1:0] prev_bottom_ff;
   logic                    prev_empty_ff;

   // Row cursors of the column at work.
   row_calc_type t1_ff, b1_ff, t2_ff, b2_ff;
   logic [COLUMN_BITS-1:0] x_col_ff;
   logic [COLUMN_BITS-1:0] x_end_ff;

   // Span start memory with registered read.
   logic [COLUMN_BITS-1:0] span_start_mem [MAX_ROWS];
   logic [COLUMN_BITS-1:0] mem_q_ff;

   // Span stage beside the memory read, then the response register.
   logic                   stage_valid_ff;
   logic [ROW_W-1:0]       stage_row_ff;
   logic                   stage_last_ff;
   logic [COLUMN_BITS-1:0] stage_x_end_ff;
   logic                   rsp_valid_ff;
   logic [ROW_W-1:0]       rsp_row_ff;
   logic [COLUMN_BITS-1:0] rsp_x_start_ff;
   logic [COLUMN_BITS-1:0] rsp_x_end_ff;
   logic                   rsp_last_ff;

   // Load values.
   logic [VH_W-1:0]        vh;
   row_calc_type           vh_calc;
   row_calc_type           vh_dec;
   logic                   prev_none;
   row_calc_type           t1_ld, b1_raw, b1_ld, t2_ld, b2_raw, b2_ld;
   logic [COLUMN_BITS-1:0] x_col_ld;

   // Sweep limits and stepping.
   row_calc_type lim1, lim2, lim3, lim4, lim4_a;
   row_calc_type b1_inc, b2_inc, t1_dec, t2_dec, t1_inc, b1_dec, lim2_next;
   logic         more1, more2, more3, more4;
   logic         last_top, last_bot;
   logic         emit_fire, mem_we;
   row_calc_type emit_row, wr_row;
   logic         emit_last;
   logic         stage_move;

   logic [X_IN_W-1:0] x_start_wide;
   logic [X_IN_W-1:0] x_end_wide;

   // Visible rows and the extents of both columns, bottoms clamped.
   always_comb begin
      vh        = (view_height_ff > MAX_ROWS_VH) ? MAX_ROWS_VH : view_height_ff;
      vh_calc   = $signed({{(ROW_CALC_W-VH_W){1'b0}}, vh});
      vh_dec    = vh_calc - ROW_ONE;
      prev_none = prev_empty_ff | req.plane_start;
      t1_ld     = prev_none ? ROW_NONE
                            : $signed({{(ROW_CALC_W-ROW_W){1'b0}}, prev_top_ff});
      b1_raw    = prev_none ? ROW_MINUS_ONE
                            : $signed({{(ROW_CALC_W-BOT_W){prev_bottom_ff[BOT_W-1]}},
                                       prev_bottom_ff});
      b1_ld     = (b1_raw >= vh_calc) ? vh_dec : b1_raw;
      t2_ld     = req.column_empty ? ROW_NONE
                            : $signed({{(ROW_CALC_W-ROW_W){1'b0}}, req.column_top});
      b2_raw    = req.column_empty ? ROW_MINUS_ONE
                            : $signed({{(ROW_CALC_W-BOT_W){req.column_bottom[BOT_W-1]}},
                                       req.column_bottom});
      b2_ld     = (b2_raw >= vh_calc) ? vh_dec : b2_raw;
      x_col_ld  = req.column_x[COLUMN_BITS-1:0];
   end

   // Limits of the four sweeps, taken from the cursors as they stand.
   always_comb begin
      b1_inc    = b1_ff + ROW_ONE;
      b2_inc    = b2_ff + ROW_ONE;
      t1_dec    = t1_ff - ROW_ONE;
      t2_dec    = t2_ff - ROW_ONE;
      t1_inc    = t1_ff + ROW_ONE;
      b1_dec    = b1_ff - ROW_ONE;
      lim1      = (b1_inc < t2_ff) ? b1_inc : t2_ff;
      lim2      = (t1_dec > b2_ff) ? t1_dec : b2_ff;
      lim3      = (b2_inc < t1_ff) ? b2_inc : t1_ff;
      lim4_a    = (t2_dec > b1_ff) ? t2_dec : b1_ff;
      lim4      = (lim4_a > ROW_MINUS_ONE) ? lim4_a : ROW_MINUS_ONE;
      lim2_next = (t1_ff > b2_ff) ? t1_ff : b2_ff;
      more1     = t1_ff < lim1;
      more2     = b1_ff > lim2;
      more3     = t2_ff < lim3;
      more4     = b2_ff > lim4;
      // The last top span is the last overall when no bottom span follows.
      last_top  = (t1_inc >= lim1) && !(b1_ff > lim2_next);
      last_bot  = !(b1_dec > lim2);
   end

   // Stage hands over when the response register is free or being taken.
   assign stage_move = stage_valid_ff && (!rsp_valid_ff || rsp_if.ready);

   // Per-sweep selection of status, emitted row and written row.
   always_comb begin
      emit_fire        = 1'b0;
      mem_we           = 1'b0;
      emit_row         = t1_ff;
      emit_last        = last_top;
      wr_row           = t2_ff;
      status.more      = 1'b0;
      status.emit_room = !stage_valid_ff || stage_move;
      unique case (cmd.phase)
         PH_TOP_CLOSE: begin
            status.more = more1;
            emit_fire   = cmd.step;
         end
         PH_BOT_CLOSE: begin
            status.more = more2;
            emit_fire   = cmd.step;
            emit_row    = b1_ff;
            emit_last   = last_bot;
         end
         PH_TOP_OPEN: begin
            status.more = more3;
            mem_we      = cmd.step;
         end
         PH_BOT_OPEN: begin
            status.more = more4;
            mem_we      = cmd.step;
            wr_row      = b2_ff;
         end
         default: begin
            status.more = 1'b0;
         end
      endcase
   end

   // Configuration register; write only while the block is idle (not enforced).
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         view_height_ff <= VIEW_HEIGHT_RESET;
      end else if (csr_if.valid) begin
         view_height_ff <= csr_if.data;
      end
   end

   // Previous column extent, updated as each request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_top_ff    <= '0;
         prev_bottom_ff <= -7'sd1;
         prev_empty_ff  <= 1'b1;
      end else if (cmd.load) begin
         if (req.column_empty) begin
            prev_top_ff    <= '0;
            prev_bottom_ff <= -7'sd1;
            prev_empty_ff  <= 1'b1;
         end else begin
            prev_top_ff    <= req.column_top;
            prev_bottom_ff <= req.column_bottom;
            prev_empty_ff  <= 1'b0;
         end
      end
   end

   // Row cursors: loaded per request, then moved one row per step.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t1_ff    <= t1_ld;
         b1_ff    <= b1_ld;
         t2_ff    <= t2_ld;
         b2_ff    <= b2_ld;
         x_col_ff <= x_col_ld;
         x_end_ff <= x_col_ld - COLUMN_BITS'(1);
      end else if (cmd.step) begin
         unique case (cmd.phase)
            PH_TOP_CLOSE: t1_ff <= t1_inc;
            PH_BOT_CLOSE: b1_ff <= b1_dec;
            PH_TOP_OPEN:  t2_ff <= t2_ff + ROW_ONE;
            PH_BOT_OPEN:  b2_ff <= b2_ff - ROW_ONE;
            default:      t1_ff <= t1_ff;
         endcase
      end
   end

   // Span start memory: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         span_start_mem[wr_row[ADDR_W-1:0]] <= x_col_ff;
      end
      if (emit_fire) begin
         mem_q_ff <= span_start_mem[emit_row[ADDR_W-1:0]];
      end
   end

   // Span stage travels alongside the memory read.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         stage_valid_ff <= 1'b1;
      end else if (stage_move) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         stage_row_ff   <= emit_row[ROW_W-1:0];
         stage_last_ff  <= emit_last;
         stage_x_end_ff <= x_end_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_row_ff     <= stage_row_ff;
         rsp_x_start_ff <= mem_q_ff;
         rsp_x_end_ff   <= stage_x_end_ff;
         rsp_last_ff    <= stage_last_ff;
      end
   end

   // Column values fit the 11-bit span fields by zero extension or truncation.
   assign x_start_wide        = X_IN_W'(rsp_x_start_ff);
   assign x_end_wide          = X_IN_W'(rsp_x_end_ff);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.span_row     = rsp_row_ff;
   assign rsp_if.span_x_start = x_start_wide[XF_W-1:0];
   assign rsp_if.span_x_end   = x_end_wide[XF_W-1:0];
   assign rsp_if.span_last    = rsp_last_ff;

`ifndef SYNTH
   // A closed span always names a row that the memory holds.
   a_emit_row_range: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> (emit_row >= 0) && (emit_row < MAX_ROWS_CALC))
      else $error("emitted span row outside the row store");

   // An opened row always lands inside the memory.
   a_write_row_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (wr_row >= 0) && (wr_row < MAX_ROWS_CALC))
      else $error("span start written outside the row store");

   // A held span stage is never overwritten by a new read.
   a_stage_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_move) |-> !emit_fire)
      else $error("span stage overwritten while held");
`endif

endmodule
